>>> hdl/fisp_pkg.sv
// Shared types and constants for the firmware image stream parser.
package fisp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SEGHDR,
		PH_DATA,
		PH_PAD,
		PH_IDLE
	} phase_t;

	localparam logic [2:0] EV_CONSUMED    = 3'd0;
	localparam logic [2:0] EV_HEADER_DONE = 3'd1;
	localparam logic [2:0] EV_SEG_HEADER  = 3'd2;
	localparam logic [2:0] EV_DATA_BYTE   = 3'd3;
	localparam logic [2:0] EV_CHECKSUM    = 3'd4;
	localparam logic [2:0] EV_ERROR       = 3'd5;
	localparam logic [2:0] EV_IGNORED     = 3'd6;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_INVALID    = 2'd1;
	localparam logic [1:0] ERR_SUSPICIOUS = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

	localparam logic [2:0] REG_IMAGE_MAGIC    = 3'd0;
	localparam logic [2:0] REG_MAX_SEG_COUNT  = 3'd1;
	localparam logic [2:0] REG_OFFSET_LOWEST  = 3'd2;
	localparam logic [2:0] REG_OFFSET_HIGHEST = 3'd3;
	localparam logic [2:0] REG_MAX_SEG_LENGTH = 3'd4;

	localparam logic [7:0]  MAGIC_RESET       = 8'd233;
	localparam logic [4:0]  SEG_COUNT_RESET   = 5'd16;
	localparam logic [31:0] OFFSET_LOW_RESET  = 32'h3ffe_0000;
	localparam logic [31:0] OFFSET_HIGH_RESET = 32'h4020_0000;
	localparam logic [16:0] SEG_LENGTH_RESET  = 17'h1_0000;

	localparam logic [3:0]  CHECKSUM_POSITION = 4'd15;
	localparam logic [2:0]  LAST_FIELD_BYTE   = 3'd7;

endpackage

>>> hdl/firmware_image_stream_parser_unit.sv
// Firmware image stream parser: header and segment checks, one byte per request.
// The result of a request is registered and shown in the cycle after it is accepted.
// Throughput: one request per cycle unless a result is stalled; the state update and the result are one
// combinational pass between the parser state and the result register.
// in_ready stays high while the result register is empty or being drained.
// Reset: asynchronous; parser returns to the header phase at stream position 0,
// configuration registers take their default values, no result pending.
module firmware_image_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  image_byte,
	input  logic        end_marker,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [1:0]  error_code,
	output logic [7:0]  flash_mode,
	output logic [7:0]  flash_size_freq,
	output logic [31:0] entry_address,
	output logic [3:0]  segment_number,
	output logic [31:0] segment_offset,
	output logic [31:0] segment_length,
	output logic [7:0]  data_byte,
	output logic [7:0]  image_checksum,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration
	logic [7:0]  magic_q;
	logic [4:0]  max_count_q;
	logic [31:0] offset_low_q;
	logic [31:0] offset_high_q;
	logic [16:0] max_length_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q       <= fisp_pkg::MAGIC_RESET;
			max_count_q   <= fisp_pkg::SEG_COUNT_RESET;
			offset_low_q  <= fisp_pkg::OFFSET_LOW_RESET;
			offset_high_q <= fisp_pkg::OFFSET_HIGH_RESET;
			max_length_q  <= fisp_pkg::SEG_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (paddr[4:2])
				fisp_pkg::REG_IMAGE_MAGIC:    magic_q       <= pwdata[7:0];
				fisp_pkg::REG_MAX_SEG_COUNT:  max_count_q   <= pwdata[4:0];
				fisp_pkg::REG_OFFSET_LOWEST:  offset_low_q  <= pwdata;
				fisp_pkg::REG_OFFSET_HIGHEST: offset_high_q <= pwdata;
				fisp_pkg::REG_MAX_SEG_LENGTH: max_length_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			fisp_pkg::REG_IMAGE_MAGIC:    prdata = {24'd0, magic_q};
			fisp_pkg::REG_MAX_SEG_COUNT:  prdata = {27'd0, max_count_q};
			fisp_pkg::REG_OFFSET_LOWEST:  prdata = offset_low_q;
			fisp_pkg::REG_OFFSET_HIGHEST: prdata = offset_high_q;
			fisp_pkg::REG_MAX_SEG_LENGTH: prdata = {15'd0, max_length_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// parser state
	fisp_pkg::phase_t phase_q, phase_d;
	logic [2:0]  fbi_q, fbi_d;
	logic [31:0] word_q, word_d;
	logic [7:0]  count_hold_q, count_hold_d;
	logic [4:0]  segs_left_q, segs_left_d;
	logic [3:0]  seg_num_q, seg_num_d;
	logic [31:0] held_q, held_d;
	logic [16:0] bytes_left_q, bytes_left_d;
	logic [3:0]  pos_q, pos_d;

	logic        accept;
	logic [31:0] shifted;
	logic [16:0] bytes_dec;
	logic [4:0]  segs_dec;
	logic        hdr_bad;
	logic        seg_bad;

	assign in_ready  = !out_valid || out_ready;
	assign accept    = in_valid && in_ready;
	assign shifted   = {image_byte, word_q[31:8]};
	assign bytes_dec = bytes_left_q - 17'd1;
	assign segs_dec  = segs_left_q - 5'd1;
	assign hdr_bad   = (held_q[7:0] != magic_q) || (count_hold_q > {3'd0, max_count_q});
	assign seg_bad   = (held_q > offset_high_q) || (held_q < offset_low_q) ||
		(shifted > {15'd0, max_length_q});

	// next state
	always_comb begin
		phase_d      = phase_q;
		fbi_d        = fbi_q;
		word_d       = word_q;
		count_hold_d = count_hold_q;
		segs_left_d  = segs_left_q;
		seg_num_d    = seg_num_q;
		held_d       = held_q;
		bytes_left_d = bytes_left_q;
		pos_d        = pos_q;
		if (accept) begin
			if (end_marker) begin
				phase_d      = fisp_pkg::PH_HEADER;
				fbi_d        = 3'd0;
				word_d       = 32'd0;
				count_hold_d = 8'd0;
				segs_left_d  = 5'd0;
				seg_num_d    = 4'd0;
				held_d       = 32'd0;
				bytes_left_d = 17'd0;
				pos_d        = 4'd0;
			end else if (phase_q != fisp_pkg::PH_IDLE) begin
				pos_d = pos_q + 4'd1;
				unique case (phase_q)
					fisp_pkg::PH_HEADER: begin
						case (fbi_q)
							3'd0: held_d = {24'd0, image_byte};
							3'd1: count_hold_d = image_byte;
							3'd2: held_d[23:16] = image_byte;
							3'd3: held_d[31:24] = image_byte;
							default: word_d = shifted;
						endcase
						if (fbi_q == fisp_pkg::LAST_FIELD_BYTE) begin
							fbi_d = 3'd0;
							if (hdr_bad) begin
								phase_d = fisp_pkg::PH_IDLE;
							end else begin
								segs_left_d = count_hold_q[4:0];
								seg_num_d   = 4'd0;
								phase_d     = (count_hold_q[4:0] == 5'd0) ?
									fisp_pkg::PH_PAD : fisp_pkg::PH_SEGHDR;
							end
						end else begin
							fbi_d = fbi_q + 3'd1;
						end
					end
					fisp_pkg::PH_SEGHDR: begin
						word_d = shifted;
						if (fbi_q == 3'd3) held_d = shifted;
						if (fbi_q == fisp_pkg::LAST_FIELD_BYTE) begin
							fbi_d = 3'd0;
							if (seg_bad) begin
								phase_d = fisp_pkg::PH_IDLE;
							end else if (shifted[16:0] == 17'd0) begin
								// empty segment completes on its header
								bytes_left_d = 17'd0;
								segs_left_d  = segs_dec;
								seg_num_d    = seg_num_q + 4'd1;
								phase_d      = (segs_dec == 5'd0) ?
									fisp_pkg::PH_PAD : fisp_pkg::PH_SEGHDR;
							end else begin
								bytes_left_d = shifted[16:0];
								phase_d      = fisp_pkg::PH_DATA;
							end
						end else begin
							fbi_d = fbi_q + 3'd1;
						end
					end
					fisp_pkg::PH_DATA: begin
						bytes_left_d = bytes_dec;
						if (bytes_dec == 17'd0) begin
							segs_left_d = segs_dec;
							seg_num_d   = seg_num_q + 4'd1;
							fbi_d       = 3'd0;
							phase_d     = (segs_dec == 5'd0) ?
								fisp_pkg::PH_PAD : fisp_pkg::PH_SEGHDR;
						end
					end
					fisp_pkg::PH_PAD: begin
						if (pos_q == fisp_pkg::CHECKSUM_POSITION) phase_d = fisp_pkg::PH_IDLE;
					end
					default: ;
				endcase
			end
		end
	end

	// result for the accepted request
	logic [2:0]  res_kind;
	logic [1:0]  res_err;
	logic [7:0]  res_mode;
	logic [7:0]  res_size;
	logic [31:0] res_entry;
	logic [3:0]  res_seg;
	logic [31:0] res_offset;
	logic [31:0] res_length;
	logic [7:0]  res_data;
	logic [7:0]  res_csum;

	always_comb begin
		res_kind   = fisp_pkg::EV_CONSUMED;
		res_err    = fisp_pkg::ERR_NONE;
		res_mode   = 8'd0;
		res_size   = 8'd0;
		res_entry  = 32'd0;
		res_seg    = 4'd0;
		res_offset = 32'd0;
		res_length = 32'd0;
		res_data   = 8'd0;
		res_csum   = 8'd0;
		if (end_marker) begin
			if (phase_q == fisp_pkg::PH_IDLE) begin
				res_kind = fisp_pkg::EV_IGNORED;
			end else begin
				res_kind = fisp_pkg::EV_ERROR;
				res_err  = fisp_pkg::ERR_TRUNCATED;
			end
		end else begin
			unique case (phase_q)
				fisp_pkg::PH_HEADER: begin
					if (fbi_q == fisp_pkg::LAST_FIELD_BYTE) begin
						if (hdr_bad) begin
							res_kind = fisp_pkg::EV_ERROR;
							res_err  = fisp_pkg::ERR_INVALID;
						end else begin
							res_kind  = fisp_pkg::EV_HEADER_DONE;
							res_mode  = held_q[23:16];
							res_size  = held_q[31:24];
							res_entry = shifted;
						end
					end
				end
				fisp_pkg::PH_SEGHDR: begin
					if (fbi_q == fisp_pkg::LAST_FIELD_BYTE) begin
						res_seg    = seg_num_q;
						res_offset = held_q;
						res_length = shifted;
						if (seg_bad) begin
							res_kind = fisp_pkg::EV_ERROR;
							res_err  = fisp_pkg::ERR_SUSPICIOUS;
						end else begin
							res_kind = fisp_pkg::EV_SEG_HEADER;
						end
					end
				end
				fisp_pkg::PH_DATA: begin
					res_kind   = fisp_pkg::EV_DATA_BYTE;
					res_seg    = seg_num_q;
					res_offset = held_q;
					res_length = {15'd0, bytes_dec};
					res_data   = image_byte;
				end
				fisp_pkg::PH_PAD: begin
					if (pos_q == fisp_pkg::CHECKSUM_POSITION) begin
						res_kind = fisp_pkg::EV_CHECKSUM;
						res_csum = image_byte;
					end
				end
				default: res_kind = fisp_pkg::EV_IGNORED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= fisp_pkg::PH_HEADER;
			fbi_q        <= 3'd0;
			word_q       <= 32'd0;
			count_hold_q <= 8'd0;
			segs_left_q  <= 5'd0;
			seg_num_q    <= 4'd0;
			held_q       <= 32'd0;
			bytes_left_q <= 17'd0;
			pos_q        <= 4'd0;
		end else begin
			phase_q      <= phase_d;
			fbi_q        <= fbi_d;
			word_q       <= word_d;
			count_hold_q <= count_hold_d;
			segs_left_q  <= segs_left_d;
			seg_num_q    <= seg_num_d;
			held_q       <= held_d;
			bytes_left_q <= bytes_left_d;
			pos_q        <= pos_d;
		end
	end

	// result register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [1:0]  err_q;
	logic [7:0]  mode_q;
	logic [7:0]  size_q;
	logic [31:0] entry_q;
	logic [3:0]  seg_q;
	logic [31:0] offset_q;
	logic [31:0] length_q;
	logic [7:0]  data_q;
	logic [7:0]  csum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= res_kind;
			err_q    <= res_err;
			mode_q   <= res_mode;
			size_q   <= res_size;
			entry_q  <= res_entry;
			seg_q    <= res_seg;
			offset_q <= res_offset;
			length_q <= res_length;
			data_q   <= res_data;
			csum_q   <= res_csum;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_kind      = kind_q;
	assign error_code      = err_q;
	assign flash_mode      = mode_q;
	assign flash_size_freq = size_q;
	assign entry_address   = entry_q;
	assign segment_number  = seg_q;
	assign segment_offset  = offset_q;
	assign segment_length  = length_q;
	assign data_byte       = data_q;
	assign image_checksum  = csum_q;

endmodule

>>> hdl/fisp_checker.sv
// Port-level assertions for the firmware image stream parser, bound to the top level.
module fisp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        end_marker,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_kind,
	input logic [1:0]  error_code
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(error_code))
		else $error("result changed while stalled");

	// error code is set exactly with error events
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == fisp_pkg::EV_ERROR) == (error_code != fisp_pkg::ERR_NONE)))
		else $error("error code does not match event kind");

	// every accepted request yields a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no result");

	// an end marker gives either a truncation error or is ignored
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_marker |=>
		(event_kind == fisp_pkg::EV_IGNORED) ||
		(event_kind == fisp_pkg::EV_ERROR && error_code == fisp_pkg::ERR_TRUNCATED))
		else $error("bad result for end marker");

	// a byte never reports truncation
	a_byte_no_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !end_marker |=> error_code != fisp_pkg::ERR_TRUNCATED)
		else $error("truncation reported for a data byte");

endmodule

bind firmware_image_stream_parser_unit fisp_checker u_fisp_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the firmware image stream parser unit.
module tb;

	localparam int CLK_HALF = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_SETTING = 190;
	localparam logic [8:0] END_ITEM = 9'h100;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  err;
		logic [7:0]  mode;
		logic [7:0]  size_freq;
		logic [31:0] entry;
		logic [3:0]  seg_no;
		logic [31:0] seg_offset;
		logic [31:0] seg_length;
		logic [7:0]  payload;
		logic [7:0]  checksum;
	} parse_event_t;

	typedef enum {IMG_GOOD, IMG_TRUNC, IMG_BAD_HEADER, IMG_BAD_SEGMENT,
		IMG_NOISE} image_flavor_t;
	typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  image_byte = '0;
	logic        end_marker = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [1:0]  error_code;
	logic [7:0]  flash_mode;
	logic [7:0]  flash_size_freq;
	logic [31:0] entry_address;
	logic [3:0]  segment_number;
	logic [31:0] segment_offset;
	logic [31:0] segment_length;
	logic [7:0]  data_byte;
	logic [7:0]  image_checksum;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor copy of the configuration and parser state
	logic [7:0]  cfg_magic;
	logic [4:0]  cfg_max_segs;
	logic [31:0] cfg_off_lo;
	logic [31:0] cfg_off_hi;
	logic [16:0] cfg_max_len;
	fisp_pkg::phase_t ps_phase;
	logic [2:0]  ps_field_idx;
	logic [31:0] ps_shift;
	logic [7:0]  ps_count_byte;
	logic [4:0]  ps_segs_left;
	logic [3:0]  ps_seg_no;
	logic [31:0] ps_hold;
	logic [16:0] ps_bytes_left;
	logic [3:0]  ps_pos;

	logic [8:0]   build_items[$];
	logic [8:0]   pending_items[$];
	parse_event_t expected_events[$];
	logic [8:0]   next_item;
	parse_event_t want;
	int items_queued = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_used = 1;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int long_hold = 0;
	bit long_hold_done = 1'b0;
	int mode_left = 0;
	rx_pattern_t ready_mode = RX_ALWAYS;
	int kind_count[8];
	int err_count[4];

	firmware_image_stream_parser_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.image_byte(image_byte),
		.end_marker(end_marker),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.error_code(error_code),
		.flash_mode(flash_mode),
		.flash_size_freq(flash_size_freq),
		.entry_address(entry_address),
		.segment_number(segment_number),
		.segment_offset(segment_offset),
		.segment_length(segment_length),
		.data_byte(data_byte),
		.image_checksum(image_checksum),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic void restart_parse();
		ps_phase = fisp_pkg::PH_HEADER;
		ps_field_idx = '0;
		ps_shift = '0;
		ps_count_byte = '0;
		ps_segs_left = '0;
		ps_seg_no = '0;
		ps_hold = '0;
		ps_bytes_left = '0;
		ps_pos = '0;
	endfunction

	function automatic void close_segment();
		ps_segs_left = ps_segs_left - 5'd1;
		ps_seg_no = ps_seg_no + 4'd1;
		ps_phase = (ps_segs_left == 0) ? fisp_pkg::PH_PAD : fisp_pkg::PH_SEGHDR;
		ps_field_idx = '0;
	endfunction

	function automatic parse_event_t next_parse_event(input logic [7:0] b, input logic last);
		parse_event_t ev;
		ev = '0;
		if (last) begin
			ev.kind = (ps_phase == fisp_pkg::PH_IDLE) ? fisp_pkg::EV_IGNORED : fisp_pkg::EV_ERROR;
			ev.err = (ps_phase == fisp_pkg::PH_IDLE) ? fisp_pkg::ERR_NONE :
				fisp_pkg::ERR_TRUNCATED;
			restart_parse();
			return ev;
		end
		if (ps_phase == fisp_pkg::PH_IDLE) begin
			ev.kind = fisp_pkg::EV_IGNORED;
			return ev;
		end
		ev.kind = fisp_pkg::EV_CONSUMED;
		case (ps_phase)
		fisp_pkg::PH_HEADER: begin
			// magic, mode and size bytes share one word; the count byte is held apart
			case (ps_field_idx)
			3'd0: ps_hold = {24'd0, b};
			3'd1: ps_count_byte = b;
			3'd2: ps_hold[23:16] = b;
			3'd3: ps_hold[31:24] = b;
			default: ps_shift = {b, ps_shift[31:8]};
			endcase
			if (ps_field_idx == fisp_pkg::LAST_FIELD_BYTE) begin
				if (ps_hold[7:0] != cfg_magic || ps_count_byte > cfg_max_segs) begin
					ev.kind = fisp_pkg::EV_ERROR;
					ev.err = fisp_pkg::ERR_INVALID;
					ps_phase = fisp_pkg::PH_IDLE;
				end else begin
					ev.kind = fisp_pkg::EV_HEADER_DONE;
					ev.mode = ps_hold[23:16];
					ev.size_freq = ps_hold[31:24];
					ev.entry = ps_shift;
					ps_segs_left = ps_count_byte[4:0];
					ps_seg_no = '0;
					ps_phase = (ps_segs_left == 0) ? fisp_pkg::PH_PAD : fisp_pkg::PH_SEGHDR;
				end
				ps_field_idx = '0;
			end else begin
				ps_field_idx++;
			end
		end
		fisp_pkg::PH_SEGHDR: begin
			ps_shift = {b, ps_shift[31:8]};
			if (ps_field_idx == 3'd3)
				ps_hold = ps_shift;
			if (ps_field_idx == fisp_pkg::LAST_FIELD_BYTE) begin
				ev.seg_no = ps_seg_no;
				ev.seg_offset = ps_hold;
				ev.seg_length = ps_shift;
				if (ps_hold > cfg_off_hi || ps_hold < cfg_off_lo ||
						ps_shift > cfg_max_len) begin
					ev.kind = fisp_pkg::EV_ERROR;
					ev.err = fisp_pkg::ERR_SUSPICIOUS;
					ps_phase = fisp_pkg::PH_IDLE;
					ps_field_idx = '0;
				end else begin
					ev.kind = fisp_pkg::EV_SEG_HEADER;
					ps_bytes_left = ps_shift[16:0];
					if (ps_bytes_left == 0) begin
						close_segment();
					end else begin
						ps_phase = fisp_pkg::PH_DATA;
						ps_field_idx = '0;
					end
				end
			end else begin
				ps_field_idx++;
			end
		end
		fisp_pkg::PH_DATA: begin
			ps_bytes_left = ps_bytes_left - 17'd1;
			ev.kind = fisp_pkg::EV_DATA_BYTE;
			ev.seg_no = ps_seg_no;
			ev.seg_offset = ps_hold;
			ev.seg_length = {15'd0, ps_bytes_left};
			ev.payload = b;
			if (ps_bytes_left == 0)
				close_segment();
		end
		default: begin
			if (ps_pos == fisp_pkg::CHECKSUM_POSITION) begin
				ev.kind = fisp_pkg::EV_CHECKSUM;
				ev.checksum = b;
				ps_phase = fisp_pkg::PH_IDLE;
			end
		end
		endcase
		ps_pos = ps_pos + 4'd1;
		return ev;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val, act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		fisp_pkg::REG_IMAGE_MAGIC:    cfg_magic = value[7:0];
		fisp_pkg::REG_MAX_SEG_COUNT:  cfg_max_segs = value[4:0];
		fisp_pkg::REG_OFFSET_LOWEST:  cfg_off_lo = value;
		fisp_pkg::REG_OFFSET_HIGHEST: cfg_off_hi = value;
		fisp_pkg::REG_MAX_SEG_LENGTH: cfg_max_len = value[16:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] magic, input logic [4:0] max_segs,
			input logic [31:0] lo, input logic [31:0] hi, input logic [16:0] max_len);
		write_reg(fisp_pkg::REG_IMAGE_MAGIC, {24'd0, magic});
		write_reg(fisp_pkg::REG_MAX_SEG_COUNT, {27'd0, max_segs});
		write_reg(fisp_pkg::REG_OFFSET_LOWEST, lo);
		write_reg(fisp_pkg::REG_OFFSET_HIGHEST, hi);
		write_reg(fisp_pkg::REG_MAX_SEG_LENGTH, {15'd0, max_len});
		settings_used++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		build_items.push_back({1'b0, b});
	endtask

	task automatic add_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			add_byte(w[8*i +: 8]);
	endtask

	task automatic commit_build();
		while (build_items.size() != 0) begin
			pending_items.push_back(build_items.pop_front());
			items_queued++;
		end
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || expected_events.size() != 0)
			@(posedge clk);
	endtask

	// one image built against the current register values, always closed by an end marker
	task automatic queue_image(input image_flavor_t flavor);
		int nseg;
		int bad_at;
		int keep;
		bit stop;
		logic [7:0] magic;
		logic [7:0] count;
		logic [31:0] offs;
		logic [31:0] seglen;
		build_items.delete();
		if (flavor == IMG_NOISE) begin
			repeat ($urandom_range(4, 24))
				build_items.push_back({$urandom_range(0, 7) == 0, 8'($urandom)});
		end else begin
			if ($urandom_range(0, 5) == 0)
				nseg = cfg_max_segs;
			else
				nseg = $urandom_range(0, (cfg_max_segs < 4) ? cfg_max_segs : 4);
			magic = cfg_magic;
			count = 8'(nseg);
			if (flavor == IMG_BAD_HEADER) begin
				if ($urandom_range(0, 1))
					count = 8'($urandom_range(cfg_max_segs + 1, 255));
				else
					magic = cfg_magic ^ 8'($urandom_range(1, 255));
			end
			bad_at = (flavor == IMG_BAD_SEGMENT && nseg > 0) ? $urandom_range(0, nseg - 1) : -1;
			add_byte(magic);
			add_byte(count);
			add_byte(8'($urandom));
			add_byte(8'($urandom));
			add_word($urandom);
			stop = (flavor == IMG_BAD_HEADER);
			for (int i = 0; i < nseg && !stop; i++) begin
				if ($urandom_range(0, 2) == 0)
					offs = cfg_off_lo;
				else if ($urandom_range(0, 1))
					offs = cfg_off_hi;
				else
					offs = $urandom_range(cfg_off_lo, cfg_off_hi);
				seglen = $urandom_range(0, (cfg_max_len < 12) ? cfg_max_len : 12);
				if (flavor == IMG_TRUNC && $urandom_range(0, 3) == 0)
					seglen = $urandom_range(0, cfg_max_len);
				if (i == bad_at) begin
					if (cfg_off_lo != 0 && $urandom_range(0, 2) == 0)
						offs = $urandom_range(0, cfg_off_lo - 1);
					else if (cfg_off_hi != 32'hffff_ffff && $urandom_range(0, 1))
						offs = $urandom_range(cfg_off_hi + 1, 32'hffff_ffff);
					else if ($urandom_range(0, 1))
						seglen = cfg_max_len + 1;
					else
						seglen = $urandom_range(cfg_max_len + 1, 32'hffff_ffff);
					stop = 1'b1;
				end
				add_word(offs);
				add_word(seglen);
				if (!stop) begin
					// long segments only show up truncated
					repeat ((seglen > 24) ? 24 : seglen)
						add_byte(8'($urandom));
					stop = (seglen > 24);
				end
			end
			if (!stop) begin
				repeat ((15 - build_items.size() % 16) % 16)
					add_byte(8'($urandom));
				add_byte(8'($urandom));
			end
			if (flavor == IMG_TRUNC) begin
				keep = $urandom_range(build_items.size() / 2, build_items.size() - 1);
				while (build_items.size() > keep)
					void'(build_items.pop_back());
			end else begin
				repeat ($urandom_range(0, 2))
					add_byte(8'($urandom));
			end
		end
		build_items.push_back(END_ITEM);
		commit_build();
	endtask

	task automatic random_images(input int count);
		int start;
		int r;
		start = items_queued;
		while (items_queued - start < count) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				queue_image(IMG_GOOD);
			else if (r < 62)
				queue_image(IMG_TRUNC);
			else if (r < 72)
				queue_image(IMG_BAD_HEADER);
			else if (r < 86)
				queue_image(IMG_BAD_SEGMENT);
			else
				queue_image(IMG_NOISE);
		end
	endtask

	// request driver: bursts of random length, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			image_byte <= '0;
			end_marker <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_events.push_back(next_parse_event(image_byte, end_marker));
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					{end_marker, image_byte} <= next_item;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_events.size() == 0) begin
					$error("result with no request pending: event_kind %0d", event_kind);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					kind_count[want.kind]++;
					err_count[want.err]++;
					check_field("event_kind", want.kind, event_kind);
					check_field("error_code", want.err, error_code);
					check_field("flash_mode", want.mode, flash_mode);
					check_field("flash_size_freq", want.size_freq, flash_size_freq);
					check_field("entry_address", want.entry, entry_address);
					check_field("segment_number", want.seg_no, segment_number);
					check_field("segment_offset", want.seg_offset, segment_offset);
					check_field("segment_length", want.seg_length, segment_length);
					check_field("data_byte", want.payload, data_byte);
					check_field("image_checksum", want.checksum, image_checksum);
				end
			end
			if (long_hold > 0) begin
				long_hold--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 300 && pending_items.size() > 20) begin
				// long hold-off while the sender keeps offering: input must stall
				long_hold_done = 1'b1;
				long_hold = 250;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = rx_pattern_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 80);
				end else begin
					mode_left--;
				end
				case (ready_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
				RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
				default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [31:0] lo_pick;
		logic [31:0] hi_pick;
		cfg_magic = fisp_pkg::MAGIC_RESET;
		cfg_max_segs = fisp_pkg::SEG_COUNT_RESET;
		cfg_off_lo = fisp_pkg::OFFSET_LOW_RESET;
		cfg_off_hi = fisp_pkg::OFFSET_HIGH_RESET;
		cfg_max_len = fisp_pkg::SEG_LENGTH_RESET;
		restart_parse();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// end at stream start, over-count header then stray byte, bare image with extreme fields
		build_items.push_back(END_ITEM);
		add_byte(cfg_magic);
		add_byte(8'd17);
		add_byte(8'h00);
		add_byte(8'hff);
		add_word(32'h0000_0000);
		add_byte(8'h00);
		build_items.push_back(END_ITEM);
		add_byte(cfg_magic);
		add_byte(8'd0);
		add_byte(8'h00);
		add_byte(8'hff);
		add_word(32'hffff_ffff);
		repeat (7)
			add_byte(8'hff);
		add_byte(8'h00);
		build_items.push_back(END_ITEM);
		commit_build();
		random_images(ITEMS_PER_SETTING);
		wait_drained();

		set_config(8'h00, 5'd0, 32'h0000_0000, 32'hffff_ffff, 17'd0);
		random_images(ITEMS_PER_SETTING);
		wait_drained();

		set_config(8'hff, 5'd16, 32'hffff_ffff, 32'hffff_ffff, 17'h1_0000);
		random_images(ITEMS_PER_SETTING);
		wait_drained();

		lo_pick = $urandom;
		hi_pick = $urandom_range(lo_pick, 32'hffff_ffff);
		set_config(8'($urandom), 5'($urandom_range(1, 16)), lo_pick, hi_pick,
			17'($urandom_range(0, 65536)));
		random_images(ITEMS_PER_SETTING);
		wait_drained();

		set_config(fisp_pkg::MAGIC_RESET, fisp_pkg::SEG_COUNT_RESET, fisp_pkg::OFFSET_LOW_RESET,
			fisp_pkg::OFFSET_HIGH_RESET, fisp_pkg::SEG_LENGTH_RESET);
		random_images(ITEMS_PER_SETTING);
		wait_drained();

		// idle cycles after draining catch any stray result
		repeat (8) @(posedge clk);
		$display("Ran %0d requests under %0d register settings: %0d consumed, %0d header,",
			items_accepted, settings_used, kind_count[fisp_pkg::EV_CONSUMED],
			kind_count[fisp_pkg::EV_HEADER_DONE]);
		$display("  %0d segment header, %0d data, %0d checksum, %0d ignored",
			kind_count[fisp_pkg::EV_SEG_HEADER], kind_count[fisp_pkg::EV_DATA_BYTE],
			kind_count[fisp_pkg::EV_CHECKSUM], kind_count[fisp_pkg::EV_IGNORED]);
		$display("Parser errors: %0d invalid image, %0d suspicious segment, %0d truncated;",
			err_count[fisp_pkg::ERR_INVALID], err_count[fisp_pkg::ERR_SUSPICIOUS],
			err_count[fisp_pkg::ERR_TRUNCATED]);
		$display("  long receiver hold %s", long_hold_done ? "applied" : "not reached");
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
